[sv/she_pkg.sv]
// ----------------------------------------------------------------------------
// she_pkg
// Shared widths, types and operation codes for the sample histogram engine.
// ----------------------------------------------------------------------------
package she_pkg;

    // Depth of the bin count store
    localparam int BIN_DEPTH = 8192;
    localparam int ADDR_W    = $clog2(BIN_DEPTH);
    // Wide enough to hold the effective bin count, up to BIN_DEPTH itself
    localparam int NEFF_W    = $clog2(BIN_DEPTH + 1);

    // Fixed field widths
    localparam int NBINS_W   = 13;
    localparam int BIN_W     = 13;
    localparam int SAMPLE_W  = 16;
    localparam int CNT_W     = 16;
    localparam int OP_W      = 2;

    localparam logic [NBINS_W-1:0] NBINS_RESET = NBINS_W'(4096);
    localparam logic [CNT_W-1:0]   CNT_MAX     = {CNT_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_ACCUMULATE = 2'd0,
        OP_READ       = 2'd1,
        OP_CLEAR      = 2'd2
    } op_t;

    // One access to the count store
    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  wdata;
    } ram_req_t;

endpackage

[sv/she_count_ram.sv]
// ----------------------------------------------------------------------------
// she_count_ram
// Single-port bin count store, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module she_count_ram (
    input  logic                              clk,
    input  she_pkg::ram_req_t                 req,
    output logic [she_pkg::CNT_W-1:0]         rd_data
);

    logic [she_pkg::CNT_W-1:0] mem [she_pkg::BIN_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data <= mem[req.addr];
        end
    end

endmodule

[sv/she_bin_map.sv]
// ----------------------------------------------------------------------------
// she_bin_map
// Maps a signed sample to its bin: registered product n*(s+32768), then
// take the upper bits and clamp to n-1.
// ----------------------------------------------------------------------------
module she_bin_map (
    input  logic                               clk,
    input  logic                               load,
    input  logic signed [she_pkg::SAMPLE_W-1:0] sample,
    input  logic [she_pkg::NEFF_W-1:0]         n_eff,
    output logic [she_pkg::ADDR_W-1:0]         bin
);

    localparam int PROD_W = she_pkg::NEFF_W + she_pkg::SAMPLE_W;

    logic [PROD_W-1:0]               prod_reg;
    logic [she_pkg::SAMPLE_W-1:0]    offset;
    logic [she_pkg::NEFF_W-1:0]      raw_bin;

    // Flip the sign bit: s + 32768 as unsigned
    assign offset = {~sample[she_pkg::SAMPLE_W-1], sample[she_pkg::SAMPLE_W-2:0]};

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= PROD_W'(n_eff) * PROD_W'(offset);
        end
    end

    assign raw_bin = prod_reg[PROD_W-1:she_pkg::SAMPLE_W];

    always_comb
    begin
        if (raw_bin >= n_eff)
        begin
            bin = she_pkg::ADDR_W'(n_eff - she_pkg::NEFF_W'(1));
        end
        else
        begin
            bin = she_pkg::ADDR_W'(raw_bin);
        end
    end

endmodule

[sv/sample_histogram_engine_unit.sv]
// ----------------------------------------------------------------------------
// sample_histogram_engine_unit
// Equal-width bin histogram of signed 16-bit samples with saturating counts.
// ----------------------------------------------------------------------------
// Each transaction accumulates a sample, reads one bin count or clears all
// bins, and yields exactly one result transaction. An accumulate or an
// in-range read runs these steps from acceptance to the next possible
// acceptance: the bin multiply, addressing the count store, its registered
// read with the write-back, and moving the result into the output register.
// An out-of-range read skips the store read, and an unused operation code
// goes straight to the output step. A clear walks the single-port store one
// entry per cycle over all BIN_DEPTH entries, then hands over its result.
// After reset the same clearing pass runs with in_ready low and no result;
// n_bins writes are taken at any time. A finished result waits in the output
// register while the next transaction is accepted; only its hand-over stalls
// when out_ready is low. n_bins of 0 acts as 1 and values above the store
// depth act as the depth.
// ----------------------------------------------------------------------------
module sample_histogram_engine_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration
    input  logic                                cfg_wr_en,
    input  logic [she_pkg::NBINS_W-1:0]         cfg_wr_data,
    // Input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [she_pkg::OP_W-1:0]            operation,
    input  logic signed [she_pkg::SAMPLE_W-1:0] sample,
    input  logic [she_pkg::BIN_W-1:0]           bin_index,
    // Output channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [she_pkg::BIN_W-1:0]           bin_number,
    output logic [she_pkg::CNT_W-1:0]           bin_count,
    output logic                                index_out_of_range
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADDR,
        S_READ,
        S_DONE,
        S_CLEAR
    } state_t;

    state_t                          state_reg, state_next;
    logic [she_pkg::NBINS_W-1:0]     n_bins_reg;
    logic [she_pkg::OP_W-1:0]        op_reg, op_next;
    logic [she_pkg::BIN_W-1:0]       idx_reg, idx_next;
    logic [she_pkg::ADDR_W-1:0]      addr_reg, addr_next;
    logic [she_pkg::ADDR_W-1:0]      clr_addr_reg, clr_addr_next;
    logic                            clr_report_reg, clr_report_next;
    logic [she_pkg::BIN_W-1:0]       res_number_reg, res_number_next;
    logic [she_pkg::CNT_W-1:0]       res_count_reg, res_count_next;
    logic                            res_oor_reg, res_oor_next;
    logic                            out_valid_reg, out_valid_next;
    logic [she_pkg::BIN_W-1:0]       bin_number_reg, bin_number_next;
    logic [she_pkg::CNT_W-1:0]       bin_count_reg, bin_count_next;
    logic                            oor_reg, oor_next;

    logic [she_pkg::NEFF_W-1:0]      n_eff;
    logic                            accept;
    logic [she_pkg::ADDR_W-1:0]      acc_bin;
    logic [she_pkg::CNT_W-1:0]       rd_data;
    logic [she_pkg::CNT_W-1:0]       sat_count;
    she_pkg::ram_req_t               ram_req;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // Effective bin count: zero acts as one, clamp to the store depth
    always_comb
    begin
        if (n_bins_reg == '0)
        begin
            n_eff = she_pkg::NEFF_W'(1);
        end
        else if (32'(n_bins_reg) > 32'(she_pkg::BIN_DEPTH))
        begin
            n_eff = she_pkg::NEFF_W'(she_pkg::BIN_DEPTH);
        end
        else
        begin
            n_eff = she_pkg::NEFF_W'(n_bins_reg);
        end
    end

    // Configuration register, written at any time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_bins_reg <= she_pkg::NBINS_RESET;
        end
        else if (cfg_wr_en)
        begin
            n_bins_reg <= cfg_wr_data;
        end
    end

    // Multiply on acceptance, clamped bin ready in S_ADDR
    she_bin_map u_bin_map (
        .clk    (clk),
        .load   (accept),
        .sample (sample),
        .n_eff  (n_eff),
        .bin    (acc_bin)
    );

    she_count_ram u_count_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    // Saturating increment of the fetched count
    assign sat_count = (rd_data == she_pkg::CNT_MAX) ? rd_data
                                                     : rd_data + she_pkg::CNT_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        addr_next       = addr_reg;
        clr_addr_next   = clr_addr_reg;
        clr_report_next = clr_report_reg;
        res_number_next = res_number_reg;
        res_count_next  = res_count_reg;
        res_oor_next    = res_oor_reg;
        out_valid_next  = out_valid_reg;
        bin_number_next = bin_number_reg;
        bin_count_next  = bin_count_reg;
        oor_next        = oor_reg;
        ram_req         = '0;

        // Drop the result once the consumer takes it
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = operation;
                    idx_next        = bin_index;
                    res_number_next = '0;
                    res_count_next  = '0;
                    res_oor_next    = 1'b0;
                    case (operation)
                        she_pkg::OP_ACCUMULATE,
                        she_pkg::OP_READ:
                        begin
                            state_next = S_ADDR;
                        end
                        she_pkg::OP_CLEAR:
                        begin
                            clr_addr_next   = '0;
                            clr_report_next = 1'b1;
                            state_next      = S_CLEAR;
                        end
                        default:
                        begin
                            // Unused code: all-zero result, store untouched
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_ADDR:
            begin
                if (op_reg == she_pkg::OP_ACCUMULATE)
                begin
                    ram_req.re = 1'b1;
                    ram_req.addr = acc_bin;
                    addr_next  = acc_bin;
                    state_next = S_READ;
                end
                else if (32'(idx_reg) >= 32'(n_eff))
                begin
                    res_number_next = idx_reg;
                    res_oor_next    = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    ram_req.re   = 1'b1;
                    ram_req.addr = she_pkg::ADDR_W'(idx_reg);
                    state_next   = S_READ;
                end
            end

            S_READ:
            begin
                if (op_reg == she_pkg::OP_ACCUMULATE)
                begin
                    // Write back the bumped count
                    ram_req.we      = 1'b1;
                    ram_req.addr    = addr_reg;
                    ram_req.wdata   = sat_count;
                    res_number_next = she_pkg::BIN_W'(addr_reg);
                    res_count_next  = sat_count;
                end
                else
                begin
                    res_number_next = idx_reg;
                    res_count_next  = rd_data;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    bin_number_next = res_number_reg;
                    bin_count_next  = res_count_reg;
                    oor_next        = res_oor_reg;
                    state_next      = S_IDLE;
                end
            end

            S_CLEAR:
            begin
                ram_req.we    = 1'b1;
                ram_req.addr  = clr_addr_reg;
                ram_req.wdata = '0;
                clr_addr_next = clr_addr_reg + she_pkg::ADDR_W'(1);
                if (clr_addr_reg == she_pkg::ADDR_W'(she_pkg::BIN_DEPTH - 1))
                begin
                    // Reset sweep ends silently; a clear operation reports
                    state_next = clr_report_reg ? S_DONE : S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            op_reg         <= '0;
            idx_reg        <= '0;
            addr_reg       <= '0;
            clr_addr_reg   <= '0;
            clr_report_reg <= 1'b0;
            res_number_reg <= '0;
            res_count_reg  <= '0;
            res_oor_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            bin_number_reg <= '0;
            bin_count_reg  <= '0;
            oor_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            idx_reg        <= idx_next;
            addr_reg       <= addr_next;
            clr_addr_reg   <= clr_addr_next;
            clr_report_reg <= clr_report_next;
            res_number_reg <= res_number_next;
            res_count_reg  <= res_count_next;
            res_oor_reg    <= res_oor_next;
            out_valid_reg  <= out_valid_next;
            bin_number_reg <= bin_number_next;
            bin_count_reg  <= bin_count_next;
            oor_reg        <= oor_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign bin_number         = bin_number_reg;
    assign bin_count          = bin_count_reg;
    assign index_out_of_range = oor_reg;

endmodule

[sv/she_port_checker.sv]
// ----------------------------------------------------------------------------
// she_port_checker
// Port-level checks for the sample histogram engine, bound to the top level.
// ----------------------------------------------------------------------------
module she_port_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [she_pkg::BIN_W-1:0]           bin_number,
    input  logic [she_pkg::CNT_W-1:0]           bin_count,
    input  logic                                index_out_of_range
);

    // A stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(bin_number)
            && $stable(bin_count) && $stable(index_out_of_range))
        else $error("result changed while stalled");

    // An out-of-range read reports a zero count
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && index_out_of_range |-> bin_count == '0)
        else $error("out-of-range read with nonzero count");

    // One transaction at a time: busy right after acceptance
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted back to back");

    // The clearing pass after reset keeps the input closed
    a_reset_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !in_ready && !out_valid)
        else $error("input open during reset sweep");

endmodule

bind sample_histogram_engine_unit she_port_checker u_port_checker (.*);
